>>> hdl/dwte_pkg.sv
// Package for the DAQ word timestamp expander: widths, parse phases, module decode.
// No dependencies; imported by the expander top level.
package dwte_pkg;

  // Table size and derived address width
  localparam int MODULE_COUNT = 64;
  localparam int MOD_ADDR_W   = (MODULE_COUNT > 1) ? $clog2(MODULE_COUNT) : 1;

  // Fixed field widths
  localparam int WORD_W     = 32;
  localparam int TIME_W     = 64;
  localparam int LOW_W      = 28;
  localparam int MID_W      = 20;
  localparam int HDR_PART_W = 16;
  localparam int HDR_W      = 3 * HDR_PART_W;
  localparam int MOD_ID_W   = 6;
  localparam int TOP_W      = TIME_W - LOW_W;

  // Word classification codes
  localparam logic [1:0] TOP_WIDE_ID   = 2'b11;  // module in bits 27..22
  localparam logic [1:0] TOP_NARROW_ID = 2'b10;  // module in bits 29..24
  localparam logic [3:0] MARKER_CODE   = 4'h5;   // bits 23..20 of a marker word

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_HDR2,
    PH_HDR3,
    PH_DATA,
    PH_LOW,
    PH_MARK_MID,
    PH_MARK_LOW
  } phase_t;

  typedef struct packed {
    logic                has_id;
    logic [MOD_ID_W-1:0] id;
  } mod_dec_t;

  // Pull the module number out of a data word's top bits
  function automatic mod_dec_t decode_module(input logic [WORD_W-1:0] w);
    mod_dec_t d;
    d.has_id = 1'b0;
    d.id     = '0;
    case (w[31:30])
      TOP_WIDE_ID: begin
        d.has_id = 1'b1;
        d.id     = w[27:22];
      end
      TOP_NARROW_ID: begin
        d.has_id = 1'b1;
        d.id     = w[29:24];
      end
      default: begin
        d.has_id = 1'b0;
        d.id     = '0;
      end
    endcase
    return d;
  endfunction

  function automatic logic is_marker(input logic [WORD_W-1:0] w);
    return (w[31:30] == TOP_NARROW_ID) && (w[23:20] == MARKER_CODE);
  endfunction

  // A decoded module has a table entry
  function automatic logic in_table(input mod_dec_t d);
    return d.has_id && (int'(d.id) < MODULE_COUNT);
  endfunction

endpackage

>>> hdl/dwte_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the per-module timestamp table.
module dwte_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/daq_word_timestamp_expander.sv
// A result is registered (output or skid register) when its low word is accepted.
// Throughput: one payload word per cycle; in_tready drops only while two results wait
// (output register plus skid register). The module time table is read one word ahead,
// when the data word of a pair is accepted, so the pair's low word never waits for it.
// Reset (rst_n low, synchronous) clears parse phase, module marks, file base and the
// output queue; the module time RAM is not cleared, entries are read only once marked.
module daq_word_timestamp_expander (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // [31:0] stream_word
  input  logic [1:0]   in_tuser,   // [0] header_start, [1] file_start
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // [31:0] event_word, [95:32] event_time,
                                   // [101:96] module_id, [103:102] zero
  output logic [0:0]   out_tuser   // [0] module_known
);

  import dwte_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0]   word;
    logic [TIME_W-1:0]   time_val;
    logic [MOD_ID_W-1:0] id;
    logic                known;
  } result_t;

  // Parse state and stored timestamps
  phase_t                  phase_r, phase_nxt, phase_eff;
  logic [HDR_W-1:0]        header_r;
  logic [WORD_W-1:0]       held_word_r;
  logic [MID_W-1:0]        middle_r;
  logic [TIME_W-1:0]       running_r, running_nxt;
  logic [TIME_W-1:0]       file_base_r, file_base_nxt;
  logic                    file_base_set_r, file_base_set_nxt;
  logic [MODULE_COUNT-1:0] marked_r, marked_nxt;

  // Output queue
  logic    out_valid_r, skid_valid_r;
  result_t out_r, skid_r;

  // Datapath
  logic                  in_acc;
  logic                  hdr_start, file_start;
  logic [WORD_W-1:0]     in_word;
  mod_dec_t              held_dec, in_dec;
  logic                  held_known;
  logic [MOD_ADDR_W-1:0] held_idx;
  logic [MODULE_COUNT-1:0] marked_clr;
  logic [TIME_W-1:0]     file_base_eff;
  logic                  file_base_set_eff;
  logic [TIME_W-1:0]     base_sel;
  logic [TIME_W-1:0]     hdr_full, mark_time;
  logic                  res_valid;
  result_t               res;
  logic                  ram_wr_en, ram_rd_en;
  logic [TIME_W-1:0]     ram_rd_data;

  assign in_word    = in_tdata;
  assign hdr_start  = in_tuser[0];
  assign file_start = in_tuser[1];
  assign in_tready  = !skid_valid_r;
  assign in_acc     = in_tvalid && in_tready;

  // A header start restarts the parse at header word 0
  assign phase_eff = hdr_start ? PH_HDR0 : phase_r;

  // Next parse phase
  always_comb begin
    phase_nxt = phase_r;
    if (in_acc) begin
      case (phase_eff)
        PH_HDR0:     phase_nxt = PH_HDR1;
        PH_HDR1:     phase_nxt = PH_HDR2;
        PH_HDR2:     phase_nxt = PH_HDR3;
        PH_HDR3:     phase_nxt = PH_DATA;
        PH_DATA:     phase_nxt = PH_LOW;
        PH_LOW:      phase_nxt = is_marker(held_word_r) ? PH_MARK_MID : PH_DATA;
        PH_MARK_MID: phase_nxt = PH_MARK_LOW;
        PH_MARK_LOW: phase_nxt = PH_DATA;
        default:     phase_nxt = PH_HDR0;
      endcase
    end
  end

  // Decode, base selection, result assembly, table read and write enables and bookkeeping
  always_comb begin
    held_dec          = decode_module(held_word_r);
    in_dec            = decode_module(in_word);
    held_known        = in_table(held_dec);
    held_idx          = held_dec.id[MOD_ADDR_W-1:0];
    marked_clr        = file_start ? '0 : marked_r;
    file_base_eff     = file_start ? '0 : file_base_r;
    file_base_set_eff = file_start ? 1'b0 : file_base_set_r;

    if (held_known) begin
      base_sel = marked_clr[held_idx] ? ram_rd_data : file_base_eff;
    end else begin
      base_sel = running_r;
    end

    hdr_full  = {in_word[HDR_PART_W-1:0], header_r};
    mark_time = {held_word_r[HDR_PART_W-1:0], middle_r, in_word[LOW_W-1:0]};

    res_valid    = in_acc && (phase_eff == PH_LOW) && !is_marker(held_word_r);
    res.word     = held_word_r;
    res.time_val = {base_sel[TIME_W-1:LOW_W], in_word[LOW_W-1:0]};
    res.id       = held_dec.id;
    res.known    = held_known;

    ram_rd_en = in_acc && (phase_eff == PH_DATA);
    ram_wr_en = in_acc && (phase_eff == PH_MARK_LOW) && held_known;

    // Timestamp bookkeeping
    marked_nxt        = marked_r;
    file_base_nxt     = file_base_r;
    file_base_set_nxt = file_base_set_r;
    running_nxt       = running_r;
    if (in_acc) begin
      marked_nxt        = marked_clr;
      file_base_nxt     = file_base_eff;
      file_base_set_nxt = file_base_set_eff;
      case (phase_eff)
        PH_HDR3: begin
          running_nxt = hdr_full;
          if (!file_base_set_eff) begin
            file_base_nxt     = hdr_full;
            file_base_set_nxt = 1'b1;
          end
        end
        PH_MARK_LOW: begin
          running_nxt = mark_time;
          if (held_known) begin
            marked_nxt[held_idx] = 1'b1;
          end
        end
        default: begin
          running_nxt = running_r;
        end
      endcase
    end
  end

  // Per-module timestamp table
  dwte_ram #(
    .WIDTH (TIME_W),
    .DEPTH (MODULE_COUNT)
  ) u_mod_time (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (held_idx),
    .wr_data (mark_time),
    .rd_en   (ram_rd_en),
    .rd_addr (in_dec.id[MOD_ADDR_W-1:0]),
    .rd_data (ram_rd_data)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_HDR0;
      marked_r        <= '0;
      file_base_r     <= '0;
      file_base_set_r <= 1'b0;
      running_r       <= '0;
    end else begin
      phase_r         <= phase_nxt;
      marked_r        <= marked_nxt;
      file_base_r     <= file_base_nxt;
      file_base_set_r <= file_base_set_nxt;
      running_r       <= running_nxt;
    end
  end

  // Capture header parts, held data word and marker middle word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      case (phase_eff)
        PH_HDR0:     header_r[HDR_PART_W-1:0]              <= in_word[HDR_PART_W-1:0];
        PH_HDR1:     header_r[2*HDR_PART_W-1:HDR_PART_W]   <= in_word[HDR_PART_W-1:0];
        PH_HDR2:     header_r[HDR_W-1:2*HDR_PART_W]        <= in_word[HDR_PART_W-1:0];
        PH_DATA:     held_word_r                           <= in_word;
        PH_MARK_MID: middle_r                              <= in_word[MID_W-1:0];
        default:     held_word_r                           <= held_word_r;
      endcase
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (res_valid) begin
        out_r <= res;
      end
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_r.id, out_r.time_val, out_r.word};
  assign out_tuser  = out_r.known;

  // Checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a transaction while output register is empty");

  a_result_from_low: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (phase_eff == PH_LOW))
    else $error("result produced outside the low timestamp phase");

  a_hdr_to_data: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (phase_eff == PH_HDR3)) |=> (phase_r == PH_DATA))
    else $error("last header word did not advance to data phase");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !out_valid_r) |=> (out_valid_r && !skid_valid_r))
    else $error("result transaction lost on empty output queue");

  a_known_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.known) |-> (int'(out_r.id) < MODULE_COUNT))
    else $error("known module outside the table");

endmodule

>>> sim/tb_daq_word_timestamp_expander.sv
`timescale 1ns / 1ps
// Self-checking testbench for daq_word_timestamp_expander: predicts each timestamped word
// from the payload words it sends and compares every result field. Depends on dwte_pkg.
module tb_daq_word_timestamp_expander;
  import dwte_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct {
    logic [WORD_W-1:0]   word;
    logic [TIME_W-1:0]   stamp;
    logic [MOD_ID_W-1:0] id;
    logic                known;
  } stamped_word_t;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [31:0]  in_tdata   = '0;   // [31:0] stream_word
  logic [1:0]   in_tuser   = '0;   // [0] header_start, [1] file_start
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;         // [31:0] event_word, [95:32] event_time,
                                   // [101:96] module_id, [103:102] zero
  logic [0:0]   out_tuser;         // [0] module_known

  // Expander state as the testbench sees it
  phase_t              phase = PH_HDR0;
  logic [HDR_W-1:0]    hdr_parts = '0;
  logic [WORD_W-1:0]   held = '0;
  logic [MID_W-1:0]    mid = '0;
  logic [TIME_W-1:0]   run_time = '0;
  logic [TIME_W-1:0]   mod_time [MODULE_COUNT];
  logic                mod_marked [MODULE_COUNT] = '{default: 1'b0};
  logic [TIME_W-1:0]   file_base = '0;
  logic                file_base_set = 1'b0;

  stamped_word_t pending_words[$];
  stamped_word_t next_word;

  int  sender_idle_pct    = 0;
  int  stall_pct          = 0;
  bit  hold_req           = 1'b0;
  int  hold_left          = 0;
  int  quiet_cycles       = 0;
  int  input_stall_cycles = 0;
  int  words_sent         = 0;
  int  headers_done       = 0;
  int  markers_done       = 0;
  int  results_checked    = 0;
  int  mismatches         = 0;

  daq_word_timestamp_expander u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #6 clk = ~clk;

  // Module number carried in a data word's top bits
  function automatic logic [MOD_ID_W-1:0] word_module(input logic [WORD_W-1:0] w,
                                                      output logic has_id);
    has_id = 1'b1;
    if (w[31:30] == TOP_WIDE_ID) return w[27:22];
    if (w[31:30] == TOP_NARROW_ID) return w[29:24];
    has_id = 1'b0;
    return '0;
  endfunction

  // Advance the parse by one accepted word; queue the timestamped word a pair completes
  function automatic void expand_word(input logic [WORD_W-1:0] w, input logic hdr,
                                      input logic file);
    logic [MOD_ID_W-1:0] id;
    logic                has_id;
    logic                known;
    logic [TIME_W-1:0]   base;
    stamped_word_t       res;
    if (file) begin
      mod_marked    = '{default: 1'b0};
      file_base     = '0;
      file_base_set = 1'b0;
    end
    if (hdr) phase = PH_HDR0;
    case (phase)
      PH_HDR0: begin
        hdr_parts = {{(HDR_W-HDR_PART_W){1'b0}}, w[HDR_PART_W-1:0]};
        phase = PH_HDR1;
      end
      PH_HDR1: begin
        hdr_parts[31:16] = w[HDR_PART_W-1:0];
        phase = PH_HDR2;
      end
      PH_HDR2: begin
        hdr_parts[47:32] = w[HDR_PART_W-1:0];
        phase = PH_HDR3;
      end
      PH_HDR3: begin
        run_time = {w[HDR_PART_W-1:0], hdr_parts};
        if (!file_base_set) begin
          file_base     = run_time;
          file_base_set = 1'b1;
        end
        headers_done++;
        phase = PH_DATA;
      end
      PH_DATA: begin
        held  = w;
        phase = PH_LOW;
      end
      PH_LOW: begin
        if (held[31:30] == TOP_NARROW_ID && held[23:20] == MARKER_CODE) begin
          phase = PH_MARK_MID;
        end else begin
          id    = word_module(held, has_id);
          known = has_id && (int'(id) < MODULE_COUNT);
          if (!known) base = run_time;
          else if (mod_marked[id]) base = mod_time[id];
          else base = file_base;
          res.word  = held;
          res.stamp = {base[TIME_W-1:LOW_W], w[LOW_W-1:0]};
          res.id    = id;
          res.known = known;
          pending_words.push_back(res);
          phase = PH_DATA;
        end
      end
      PH_MARK_MID: begin
        mid   = w[MID_W-1:0];
        phase = PH_MARK_LOW;
      end
      default: begin
        // Marker group: upper bits from the marker word, then middle, then low word
        run_time = {held[15:0], mid, w[LOW_W-1:0]};
        id = word_module(held, has_id);
        if (has_id && int'(id) < MODULE_COUNT) begin
          mod_time[id]   = run_time;
          mod_marked[id] = 1'b1;
        end
        markers_done++;
        phase = PH_DATA;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [TIME_W-1:0] got,
                                 input logic [TIME_W-1:0] want);
    $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // Offer one word, with random idle cycles first; return at the accepting edge
  task automatic send_word(input logic [WORD_W-1:0] w, input logic hdr, input logic file);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    in_tuser  <= {file, hdr};
    do @(posedge clk); while (!in_tready);
    expand_word(w, hdr, file);
    words_sent++;
  endtask

  // Mostly a few hot modules so marked entries get reused
  function automatic logic [MOD_ID_W-1:0] pick_module();
    logic [MOD_ID_W-1:0] id;
    if ($urandom_range(99) < 70) id = MOD_ID_W'($urandom_range(7));
    else id = MOD_ID_W'($urandom_range(63));
    return id;
  endfunction

  function automatic logic [WORD_W-1:0] pick_data_word();
    logic [WORD_W-1:0] w;
    w = $urandom();
    case ($urandom_range(3))
      0: w[31] = 1'b0;
      1: begin
        w[31:30] = TOP_WIDE_ID;
        w[27:22] = pick_module();
      end
      default: begin
        w[31:30] = TOP_NARROW_ID;
        w[29:24] = pick_module();
        // keep it an ordinary data word
        if (w[23:20] == MARKER_CODE) w[20] = 1'b0;
      end
    endcase
    return w;
  endfunction

  function automatic logic [WORD_W-1:0] pick_marker_word();
    logic [WORD_W-1:0] w;
    w = $urandom();
    w[31:30] = TOP_NARROW_ID;
    w[29:24] = pick_module();
    w[23:20] = MARKER_CODE;
    return w;
  endfunction

  function automatic logic [WORD_W-1:0] pick_header_word();
    logic [WORD_W-1:0] w;
    w = $urandom();
    if ($urandom_range(9) == 0) w[15:0] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    return w;
  endfunction

  // Header, then data pairs and marker groups, with some broken groups and stray flags
  task automatic send_payload(input logic new_file, input int max_groups);
    logic lead;
    int   groups;
    int   pick;
    lead   = ($urandom_range(99) >= 5);
    groups = $urandom_range(max_groups, 1);
    for (int i = 0; i < 4; i++) send_word(pick_header_word(), (i == 0) && lead,
                                          (i == 0) && new_file);
    for (int g = 0; g < groups; g++) begin
      pick = $urandom_range(99);
      if (pick < 62) begin
        send_word(pick_data_word(), 1'b0, 1'b0);
        send_word($urandom(), 1'b0, 1'b0);
      end else if (pick < 87) begin
        send_word(pick_marker_word(), 1'b0, 1'b0);
        repeat (3) send_word($urandom(), 1'b0, 1'b0);
      end else if (pick < 94) begin
        send_word($urandom_range(1) ? pick_data_word() : pick_marker_word(), 1'b0, 1'b0);
      end else begin
        send_word($urandom(), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
  endtask

  // Word in phase 0 without header start still opens the header; file start on it
  task automatic test_header_parse();
    send_word(32'h0000_1111, 1'b0, 1'b1);
    send_word(32'hFFFF_2222, 1'b0, 1'b0);
    send_word(32'hABCD_3333, 1'b0, 1'b0);
    send_word(32'hFFFF_8001, 1'b0, 1'b0);
  endtask

  // Words with no module take the running time; an unmarked module takes the file base
  task automatic test_module_decode();
    send_word(32'h0000_0000, 1'b0, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
    send_word(32'h7FFF_FFFF, 1'b0, 1'b0);
    send_word(32'h0000_0000, 1'b0, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
    send_word(32'h1234_5678, 1'b0, 1'b0);
  endtask

  // Marker sets module 5 to all ones, then a module 5 pair picks it up
  task automatic test_marker_groups();
    send_word(32'h855F_FFFF, 1'b0, 1'b0);
    send_word(32'h0000_0000, 1'b0, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
    send_word(32'h8500_1234, 1'b0, 1'b0);
    send_word(32'h0000_0042, 1'b0, 1'b0);
  endtask

  // Header start drops a half pair and a half marker group; new file clears the marks
  task automatic test_resync();
    send_word(32'hC140_0000, 1'b0, 1'b0);
    send_word(32'h0000_0001, 1'b1, 1'b0);
    send_word(32'h0000_0002, 1'b0, 1'b0);
    send_word(32'h0000_0003, 1'b0, 1'b0);
    send_word(32'h0000_0004, 1'b0, 1'b0);
    send_word(32'h8A5A_AAAA, 1'b0, 1'b0);
    send_word(32'h0000_0000, 1'b0, 1'b0);
    send_word(32'h0000_5555, 1'b1, 1'b1);
    send_word(32'h0000_6666, 1'b0, 1'b0);
    send_word(32'h0000_7777, 1'b0, 1'b0);
    send_word(32'h0000_8888, 1'b0, 1'b0);
    send_word(32'h8500_0000, 1'b0, 1'b0);
    send_word(32'h0FFF_FFFF, 1'b0, 1'b0);
  endtask

  task automatic test_random_payloads(input int target, input int idle, input int stall);
    int stop_at;
    sender_idle_pct = idle;
    stall_pct       = stall;
    stop_at         = words_sent + target;
    while (words_sent < stop_at) send_payload($urandom_range(99) < 10, 12);
  endtask

  // Receiver holds off while words keep coming, so the block fills and stalls its input
  task automatic test_output_holdoff();
    int stop_at;
    sender_idle_pct = 0;
    stall_pct       = 0;
    hold_req        = 1'b1;
    stop_at         = words_sent + 60;
    while (words_sent < stop_at) send_payload(1'b0, 20);
  endtask

  // Drive ready: random stalls, or a counted hold-off when one is requested
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare each result transaction with the oldest expected word
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected result, event_word", TIME_W'(out_tdata[31:0]), '0);
      end else begin
        next_word = pending_words.pop_front();
        if (out_tdata[31:0] !== next_word.word)
          report_mismatch("event_word", TIME_W'(out_tdata[31:0]), TIME_W'(next_word.word));
        if (out_tdata[95:32] !== next_word.stamp)
          report_mismatch("event_time", out_tdata[95:32], next_word.stamp);
        if (out_tdata[101:96] !== next_word.id)
          report_mismatch("module_id", TIME_W'(out_tdata[101:96]), TIME_W'(next_word.id));
        if (out_tuser[0] !== next_word.known)
          report_mismatch("module_known", TIME_W'(out_tuser[0]), TIME_W'(next_word.known));
        if (out_tdata[103:102] !== 2'b00)
          report_mismatch("tdata pad bits", TIME_W'(out_tdata[103:102]), '0);
        results_checked++;
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (in_tvalid && !in_tready) input_stall_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no transaction for %0d cycles", $time, quiet_cycles);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_header_parse();
    test_module_decode();
    test_marker_groups();
    test_resync();
    test_random_payloads(230, 0, 0);
    test_random_payloads(230, 74, 0);
    test_random_payloads(230, 0, 74);
    test_random_payloads(230, 8, 8);
    test_output_holdoff();
    // Drain the remaining results, then watch for stray ones
    in_tvalid <= 1'b0;
    stall_pct = 0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d stream words: %0d headers, %0d marker groups, %0d results checked",
             words_sent, headers_done, markers_done, results_checked);
    $display("input held back on %0d cycles across idle, stall and hold-off phases",
             input_stall_cycles);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/dwte_pkg.sv
hdl/dwte_ram.sv
hdl/daq_word_timestamp_expander.sv
sim/tb_daq_word_timestamp_expander.sv
